// File: rtl/core/psc_pkg.sv
// Shared types and constants for the pedal setpoint conditioner.
package psc_pkg;

    localparam int AVG_DEPTH   = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int SLOT_BITS   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(AVG_DEPTH);

    // Divide-by-depth as multiply by rounded-up reciprocal; exact for all sums.
    localparam int RECIP_SHIFT = SUM_BITS + $clog2(AVG_DEPTH);
    localparam int RECIP_BITS  = SUM_BITS + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_L);

    localparam int FRAC_BITS  = 12;
    localparam int SCALE_BITS = 16;
    localparam int RPM_BITS   = 16;
    localparam int SPEED_BITS = 16;
    localparam int AMPS_BITS  = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

    localparam int S_DATA_BITS = 48;
    localparam int M_DATA_BITS = 48;
    localparam int M_USER_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_FWD_RPM     = 3'd1,
        CFG_REV_RPM     = 3'd2,
        CFG_MAX_CURRENT = 3'd3,
        CFG_REGEN_SCALE = 3'd4,
        CFG_DIR_SPEED   = 3'd5
    } psc_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEAN,
        ST_SCALE,
        ST_AMPS
    } psc_state_t;

    typedef struct packed {
        logic capture;
        logic mean_load;
        logic scale_load;
        logic out_load;
    } psc_cmd_t;

    typedef struct packed {
        logic out_free;
    } psc_status_t;

endpackage

// File: rtl/core/psc_ctrl.sv
// Sequencing controller for the pedal setpoint conditioner.
module psc_ctrl
    import psc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  psc_status_t status,
    output psc_cmd_t    cmd
);

    psc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_AMPS;
            ST_AMPS: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_MEAN:  cmd.mean_load  = 1'b1;
            ST_SCALE: cmd.scale_load = 1'b1;
            ST_AMPS:  cmd.out_load   = status.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/psc_datapath.sv
// Datapath: config registers, averaging rings, scaling multipliers, output register.
module psc_datapath
    import psc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,
    output logic [M_USER_BITS-1:0] m_tuser,
    input  psc_cmd_t               cmd,
    output psc_status_t            status
);

    localparam int MEAN_EXT  = (SAMPLE_BITS > FRAC_BITS) ? SAMPLE_BITS : FRAC_BITS;
    localparam int RPROD_BITS = SAMPLE_BITS + SCALE_BITS;
    localparam int RSHIFT_BITS = RPROD_BITS - 12;
    localparam int APROD_BITS = FRAC_BITS + AMPS_BITS;
    localparam int DPROD_BITS = SUM_BITS + RECIP_BITS;

    // configuration
    logic [SAMPLE_BITS-1:0]       thr_reg;
    logic signed [RPM_BITS-1:0]   fwd_rpm_reg;
    logic signed [RPM_BITS-1:0]   rev_rpm_reg;
    logic [AMPS_BITS-1:0]         max_cur_reg;
    logic [SCALE_BITS-1:0]        regen_scale_reg;
    logic signed [SPEED_BITS-1:0] dir_speed_reg;

    // state
    logic [SAMPLE_BITS-1:0] accel_ring_reg [AVG_DEPTH];
    logic [SAMPLE_BITS-1:0] regen_ring_reg [AVG_DEPTH];
    logic [SLOT_BITS-1:0]   slot_reg;
    logic                   held_dir_reg;

    // per-transaction pipeline
    logic                   dir_req_reg;
    logic                   blocked_reg;
    logic                   regen_sel_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic signed [RPM_BITS-1:0] rpm_reg;

    // output register
    logic                   out_valid_reg;
    logic signed [RPM_BITS-1:0] out_rpm_reg;
    logic [FRAC_BITS-1:0]   out_frac_reg;
    logic [AMPS_BITS-1:0]   out_amps_reg;
    logic                   out_dir_reg;
    logic                   out_regen_reg;
    logic                   out_blocked_reg;

    logic [SAMPLE_BITS-1:0]       in_accel;
    logic [SAMPLE_BITS-1:0]       in_regen;
    logic                         in_dir;
    logic signed [SPEED_BITS-1:0] in_speed;
    logic [SAMPLE_BITS-1:0]       accel_kept;
    logic [SAMPLE_BITS-1:0]       regen_kept;
    logic                         blocked_now;
    logic                         regen_hit;
    logic [SLOT_BITS-1:0]         slot_next;

    logic [SUM_BITS-1:0]    accel_sum;
    logic [SUM_BITS-1:0]    regen_sum;
    logic [SUM_BITS-1:0]    sum_sel;
    logic [DPROD_BITS-1:0]  div_prod;

    logic [RPROD_BITS-1:0]  regen_prod;
    logic [RSHIFT_BITS-1:0] regen_scaled;
    logic [FRAC_BITS-1:0]   regen_frac;
    logic [FRAC_BITS-1:0]   accel_frac;
    logic [APROD_BITS-1:0]  amps_prod;

    assign in_accel = s_tdata[SAMPLE_BITS-1:0];
    assign in_regen = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_dir   = s_tdata[2*SAMPLE_BITS];
    assign in_speed = s_tdata[2*SAMPLE_BITS+SPEED_BITS:2*SAMPLE_BITS+1];

    assign accel_kept  = (in_accel >= thr_reg) ? in_accel : '0;
    assign regen_kept  = (in_regen >= thr_reg) ? in_regen : '0;
    assign blocked_now = (in_dir != held_dir_reg) && (in_speed > dir_speed_reg);
    assign regen_hit   = in_regen > thr_reg;
    assign slot_next   = (slot_reg == SLOT_BITS'(AVG_DEPTH - 1)) ?
                         '0 : slot_reg + SLOT_BITS'(1);

    always_comb begin
        accel_sum = '0;
        regen_sum = '0;
        for (int k = 0; k < AVG_DEPTH; k++) begin
            accel_sum = accel_sum + SUM_BITS'(accel_ring_reg[k]);
            regen_sum = regen_sum + SUM_BITS'(regen_ring_reg[k]);
        end
    end

    assign sum_sel  = regen_sel_reg ? regen_sum : accel_sum;
    assign div_prod = DPROD_BITS'(sum_sel) * DPROD_BITS'(RECIP);

    assign regen_prod   = RPROD_BITS'(mean_reg) * RPROD_BITS'(regen_scale_reg);
    assign regen_scaled = regen_prod[RPROD_BITS-1:12];
    assign regen_frac   = (regen_scaled > RSHIFT_BITS'(FRAC_MAX)) ?
                          FRAC_MAX : regen_scaled[FRAC_BITS-1:0];
    assign accel_frac   = (MEAN_EXT'(mean_reg) > MEAN_EXT'(FRAC_MAX)) ?
                          FRAC_MAX : FRAC_BITS'(mean_reg);

    assign amps_prod = APROD_BITS'(frac_reg) * APROD_BITS'(max_cur_reg);

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg         <= SAMPLE_BITS'(205);
            fwd_rpm_reg     <= 16'sd20000;
            rev_rpm_reg     <= -16'sd20000;
            max_cur_reg     <= 16'd5000;
            regen_scale_reg <= 16'd4096;
            dir_speed_reg   <= 16'sd100;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                accel_ring_reg[k] <= '0;
                regen_ring_reg[k] <= '0;
            end
            slot_reg      <= '0;
            held_dir_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_THRESHOLD:   thr_reg         <= cfg_wdata[SAMPLE_BITS-1:0];
                    CFG_FWD_RPM:     fwd_rpm_reg     <= cfg_wdata;
                    CFG_REV_RPM:     rev_rpm_reg     <= cfg_wdata;
                    CFG_MAX_CURRENT: max_cur_reg     <= cfg_wdata;
                    CFG_REGEN_SCALE: regen_scale_reg <= cfg_wdata;
                    CFG_DIR_SPEED:   dir_speed_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.capture) begin
                for (int k = 0; k < AVG_DEPTH; k++) begin
                    if (slot_reg == SLOT_BITS'(k)) begin
                        accel_ring_reg[k] <= accel_kept;
                        regen_ring_reg[k] <= regen_kept;
                    end
                end
                slot_reg <= slot_next;
            end
            if (cmd.scale_load && !blocked_reg && !regen_sel_reg) begin
                held_dir_reg <= dir_req_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dir_req_reg   <= in_dir;
            blocked_reg   <= blocked_now;
            regen_sel_reg <= regen_hit && !blocked_now;
        end
        if (cmd.mean_load) begin
            mean_reg <= div_prod[RECIP_SHIFT+SAMPLE_BITS-1:RECIP_SHIFT];
        end
        if (cmd.scale_load) begin
            priority if (blocked_reg) begin
                frac_reg <= '0;
                rpm_reg  <= '0;
            end else if (regen_sel_reg) begin
                frac_reg <= regen_frac;
                rpm_reg  <= '0;
            end else begin
                frac_reg <= accel_frac;
                rpm_reg  <= dir_req_reg ? rev_rpm_reg : fwd_rpm_reg;
            end
        end
        if (cmd.out_load) begin
            out_rpm_reg     <= rpm_reg;
            out_frac_reg    <= frac_reg;
            out_amps_reg    <= amps_prod[APROD_BITS-1:12];
            out_dir_reg     <= held_dir_reg;
            out_regen_reg   <= regen_sel_reg;
            out_blocked_reg <= blocked_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_dir_reg, out_amps_reg, out_frac_reg, out_rpm_reg};
    assign m_tuser  = {out_blocked_reg, out_regen_reg};

endmodule

// File: rtl/core/pedal_setpoint_conditioner.sv
// Top level of the pedal setpoint conditioner.
// Each input transaction is one pedal/direction/speed sample and yields exactly one
// setpoint transaction. A sample runs through these steps in order: capture and ring
// update, ring sum with divide-by-depth multiply, regen scaling and branch select,
// then the current multiply into the output register, the last of three registered
// multiplies. A new sample is accepted while the previous result waits in the output
// register; the last step stalls only if that register is still full. Configuration
// registers may only be written while no sample is in flight.
module pedal_setpoint_conditioner
    import psc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // accel_pedal[11:0], regen_pedal[23:12], direction_switch[24],
    // vehicle_speed[40:25], zero fill
    input  logic [S_DATA_BITS-1:0]  s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // set_speed_rpm[15:0], set_current_fraction[27:16],
    // set_current_centiamps[43:28], direction_out[44], zero fill
    output logic [M_DATA_BITS-1:0]  m_tdata,
    // regen_active[0], interlock_blocked[1]
    output logic [M_USER_BITS-1:0]  m_tuser
);

    psc_cmd_t    cmd;
    psc_status_t status;

    psc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
